>>> sv/bzev_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the Bezier point and derivative evaluator.
// Holds the command word, the operation codes, the sequencer states and the binomial table.
package bzev_pkg;

    localparam int COORD_W = 32;
    localparam int T_W     = 17;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 4;
    localparam int PW_W    = 31;
    localparam int BIN_W   = 13;
    localparam int BIN_N   = 16;

    localparam logic [T_W-1:0]  ONE_T  = 17'd65536;
    localparam logic [PW_W-1:0] PW_ONE = 31'h4000_0000;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_POINT = 2'd1,
        OP_DERIV = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        K_LOAD,
        K_POINT,
        K_DERIV,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic                      we;
        logic [IDX_W-1:0]          idx;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [T_W-1:0]            t;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPW,
        S_PRE,
        S_RD,
        S_W,
        S_WB,
        S_MUL,
        S_ACC,
        S_RND,
        S_OUT
    } t_state;

    typedef logic [BIN_N-1:0][BIN_N-1:0][BIN_W-1:0] t_binom_tab;

    function automatic t_binom_tab build_binom();
        t_binom_tab tab;
        tab = '0;
        for (int m = 0; m < BIN_N; m++) begin
            tab[m][0] = BIN_W'(1);
            for (int i = 1; i < BIN_N; i++) begin
                if (i <= m) begin
                    tab[m][i] = tab[m-1][i-1] + tab[m-1][i];
                end
            end
        end
        return tab;
    endfunction

    localparam t_binom_tab BINOM = build_binom();

endpackage

>>> sv/bezier_point_and_derivative_eval.sv
`timescale 1ns / 1ps
// A load or a rejected item is handled in the idle state. A curve point has order m = n-1 and
// a derivative order m = n-2; each control point passes through the read, weight, binomial
// weight, multiply and accumulate steps. The engine takes one load per cycle while idle and
// no new item while an evaluation runs; the two-entry queue raises o_busy while it is full.
// Synchronous active-low reset clears the point count and control; points are unset.
module bezier_point_and_derivative_eval #(
    parameter int MAX_POINTS = 10,
    parameter int MIN_POINTS = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bzev_pkg::CNT_W-1:0]          i_cfg_data,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [1:0]                          i_operation,
    input  logic [bzev_pkg::IDX_W-1:0]          i_point_index,
    input  logic signed [bzev_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [bzev_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [bzev_pkg::COORD_W-1:0] i_coord_z,
    input  logic [bzev_pkg::T_W-1:0]            i_param_t,
    output logic                                o_done,
    output logic signed [bzev_pkg::COORD_W-1:0] o_out_x,
    output logic signed [bzev_pkg::COORD_W-1:0] o_out_y,
    output logic signed [bzev_pkg::COORD_W-1:0] o_out_z,
    output logic                                o_status
);

    logic [bzev_pkg::CNT_W-1:0] r_point_count;
    logic                       push;
    logic                       pop;
    logic                       full;
    logic                       q_valid;
    bzev_pkg::t_cmd             f_cmd;
    bzev_pkg::t_cmd             q_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (i_cfg_valid) begin
            r_point_count <= i_cfg_data;
        end
    end

    bzev_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .i_start      (i_start),
        .i_full       (full),
        .i_operation  (i_operation),
        .i_point_index(i_point_index),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_coord_z    (i_coord_z),
        .i_param_t    (i_param_t),
        .o_push       (push),
        .o_cmd        (f_cmd),
        .o_busy       (o_busy)
    );

    bzev_cmdq u_cmdq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (f_cmd),
        .i_pop  (pop),
        .o_full (full),
        .o_valid(q_valid),
        .o_cmd  (q_cmd)
    );

    bzev_back #(
        .MAX_POINTS(MAX_POINTS),
        .MIN_POINTS(MIN_POINTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_point_count(r_point_count),
        .i_valid      (q_valid),
        .i_cmd        (q_cmd),
        .o_pop        (pop),
        .o_done       (o_done),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z),
        .o_status     (o_status)
    );

endmodule

>>> sv/bzev_ram.sv
`timescale 1ns / 1ps
// Generic single write port RAM with one registered read port.
// Has no dependencies.
module bzev_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bzev_front.sv
`timescale 1ns / 1ps
// Front end: takes input items and turns them into queue commands.
// Depends on bzev_pkg.
module bzev_front #(
    parameter int MAX_POINTS = 10
) (
    input  logic                                i_start,
    input  logic                                i_full,
    input  logic [1:0]                          i_operation,
    input  logic [bzev_pkg::IDX_W-1:0]          i_point_index,
    input  logic signed [bzev_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [bzev_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [bzev_pkg::COORD_W-1:0] i_coord_z,
    input  logic [bzev_pkg::T_W-1:0]            i_param_t,
    output logic                                o_push,
    output bzev_pkg::t_cmd                      o_cmd,
    output logic                                o_busy
);

    always_comb begin
        o_cmd.idx = i_point_index;
        o_cmd.x   = i_coord_x;
        o_cmd.y   = i_coord_y;
        o_cmd.z   = i_coord_z;
        o_cmd.t   = (i_param_t > bzev_pkg::ONE_T) ? bzev_pkg::ONE_T : i_param_t;
        o_cmd.we  = ({1'b0, i_point_index} < 5'(MAX_POINTS));
        case (bzev_pkg::t_op'(i_operation))
            bzev_pkg::OP_LOAD:  o_cmd.kind = bzev_pkg::K_LOAD;
            bzev_pkg::OP_POINT: o_cmd.kind = bzev_pkg::K_POINT;
            bzev_pkg::OP_DERIV: o_cmd.kind = bzev_pkg::K_DERIV;
            default:            o_cmd.kind = bzev_pkg::K_NOP;
        endcase
    end

    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

endmodule

>>> sv/bzev_cmdq.sv
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the evaluation engine.
// Depends on bzev_pkg.
module bzev_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bzev_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output bzev_pkg::t_cmd o_cmd
);

    bzev_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];

endmodule

>>> sv/bzev_back.sv
`timescale 1ns / 1ps
// Evaluation engine: stores control points and runs the Bernstein sum with one
// shared power unit and three axis multipliers. Depends on bzev_pkg and bzev_ram.
module bzev_back #(
    parameter int MAX_POINTS = 10,
    parameter int MIN_POINTS = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [bzev_pkg::CNT_W-1:0]          i_point_count,
    input  logic                                i_valid,
    input  bzev_pkg::t_cmd                      i_cmd,
    output logic                                o_pop,
    output logic                                o_done,
    output logic signed [bzev_pkg::COORD_W-1:0] o_out_x,
    output logic signed [bzev_pkg::COORD_W-1:0] o_out_y,
    output logic signed [bzev_pkg::COORD_W-1:0] o_out_z,
    output logic                                o_status
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = bzev_pkg::COORD_W;
    localparam int VW    = CW + 1;
    localparam int PRW   = 2 * VW;
    localparam int ACW   = PRW + 4;
    localparam int RNW   = ACW - 30;
    localparam int SCW   = RNW + 5;
    localparam int PW    = bzev_pkg::PW_W;

    bzev_pkg::t_state r_state;
    bzev_pkg::t_state n_state;

    logic                    r_deriv;
    logic [AW-1:0]           r_m;
    logic [AW-1:0]           r_k;
    logic [AW-1:0]           r_i;
    logic [3:0]              r_scale;
    logic [bzev_pkg::T_W-1:0] r_t;
    logic [bzev_pkg::T_W-1:0] r_u;
    logic [PW-1:0]           r_pw;
    logic [PW-1:0]           r_stk [MAX_POINTS];
    logic [2*PW-1:0]         r_tu;
    logic [31:0]             r_b;
    logic [31:0]             r_w;
    logic signed [CW-1:0]    r_prev [3];
    logic signed [VW-1:0]    r_v [3];
    logic signed [PRW-1:0]   r_prod [3];
    logic signed [ACW-1:0]   r_acc [3];
    logic signed [RNW-1:0]   r_rnd [3];
    logic                    r_done;
    logic signed [CW-1:0]    r_out [3];
    logic                    r_status;

    logic                    count_ok;
    logic                    ram_we;
    logic [AW-1:0]           ram_raddr;
    logic [3*CW-1:0]         ram_rdata;
    logic signed [CW-1:0]    rd [3];
    logic [PW+bzev_pkg::T_W-1:0] pw_prod;
    logic [2*PW-1:0]         tu_rnd;
    logic [bzev_pkg::BIN_W+31:0] w_full;
    logic signed [SCW-1:0]   scaled [3];
    logic signed [ACW-1:0]   acc_rnd [3];

    assign count_ok = ({1'b0, i_point_count} >= 5'(MIN_POINTS)) &&
                      ({1'b0, i_point_count} <= 5'(MAX_POINTS));

    assign ram_we = (r_state == bzev_pkg::S_IDLE) && i_valid &&
                    (i_cmd.kind == bzev_pkg::K_LOAD) && i_cmd.we;

    always_comb begin
        case (r_state)
            bzev_pkg::S_RD: ram_raddr = r_i + AW'(r_deriv);
            default:        ram_raddr = '0;
        endcase
    end

    bzev_ram #(
        .WIDTH(3 * CW),
        .DEPTH(MAX_POINTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(i_cmd.idx[AW-1:0]),
        .i_wdata({i_cmd.z, i_cmd.y, i_cmd.x}),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rd[0] = ram_rdata[CW-1:0];
    assign rd[1] = ram_rdata[2*CW-1:CW];
    assign rd[2] = ram_rdata[3*CW-1:2*CW];

    assign pw_prod = (PW + bzev_pkg::T_W)'(r_pw) *
                     (PW + bzev_pkg::T_W)'((r_state == bzev_pkg::S_UPW) ? r_u : r_t)
                     + (PW + bzev_pkg::T_W)'(32768);
    assign tu_rnd  = r_tu + (2*PW)'(32'h2000_0000);
    assign w_full  = (bzev_pkg::BIN_W + 32)'(
                         bzev_pkg::BINOM[4'(r_m)][4'(r_i)]) *
                     (bzev_pkg::BIN_W + 32)'(r_b);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            acc_rnd[a] = r_acc[a] + ACW'(32'sh2000_0000);
            scaled[a]  = SCW'(r_rnd[a]) * SCW'($signed({1'b0, r_scale}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bzev_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            bzev_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    if (count_ok && (i_cmd.kind == bzev_pkg::K_POINT ||
                                     i_cmd.kind == bzev_pkg::K_DERIV)) begin
                        n_state = bzev_pkg::S_UPW;
                    end
                end
            end
            bzev_pkg::S_UPW: begin
                if (r_k == r_m) begin
                    n_state = r_deriv ? bzev_pkg::S_PRE : bzev_pkg::S_RD;
                end
            end
            bzev_pkg::S_PRE: n_state = bzev_pkg::S_RD;
            bzev_pkg::S_RD:  n_state = bzev_pkg::S_W;
            bzev_pkg::S_W:   n_state = bzev_pkg::S_WB;
            bzev_pkg::S_WB:  n_state = bzev_pkg::S_MUL;
            bzev_pkg::S_MUL: n_state = bzev_pkg::S_ACC;
            bzev_pkg::S_ACC: n_state = (r_i == r_m) ? bzev_pkg::S_RND : bzev_pkg::S_RD;
            bzev_pkg::S_RND: n_state = bzev_pkg::S_OUT;
            bzev_pkg::S_OUT: n_state = bzev_pkg::S_IDLE;
            default:         n_state = bzev_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= ((r_state == bzev_pkg::S_IDLE) && i_valid &&
                       (n_state == bzev_pkg::S_IDLE)) ||
                      (r_state == bzev_pkg::S_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            bzev_pkg::S_IDLE: begin
                r_status <= !count_ok;
                for (int a = 0; a < 3; a++) begin
                    r_out[a] <= '0;
                    r_acc[a] <= '0;
                end
                r_deriv <= (i_cmd.kind == bzev_pkg::K_DERIV);
                if (i_cmd.kind == bzev_pkg::K_DERIV) begin
                    r_m     <= AW'(i_point_count - 4'd2);
                    r_scale <= i_point_count - 4'd1;
                end else begin
                    r_m     <= AW'(i_point_count - 4'd1);
                    r_scale <= 4'd1;
                end
                r_t  <= i_cmd.t;
                r_u  <= bzev_pkg::ONE_T - i_cmd.t;
                r_pw <= bzev_pkg::PW_ONE;
                r_k  <= '0;
                r_i  <= '0;
            end
            bzev_pkg::S_UPW: begin
                r_stk[0] <= r_pw;
                for (int j = 1; j < MAX_POINTS; j++) begin
                    r_stk[j] <= r_stk[j-1];
                end
                r_k  <= r_k + AW'(1);
                r_pw <= (r_k == r_m) ? bzev_pkg::PW_ONE : pw_prod[PW+15:16];
            end
            bzev_pkg::S_RD: begin
                r_tu <= (2*PW)'(r_pw) * (2*PW)'(r_stk[0]);
                if (r_deriv && r_i == '0) begin
                    for (int a = 0; a < 3; a++) begin
                        r_prev[a] <= rd[a];
                    end
                end
            end
            bzev_pkg::S_W: begin
                r_b <= tu_rnd[61:30];
                for (int a = 0; a < 3; a++) begin
                    r_prev[a] <= rd[a];
                    r_v[a]    <= r_deriv ? (VW'(rd[a]) - VW'(r_prev[a])) : VW'(rd[a]);
                end
                r_pw <= pw_prod[PW+15:16];
                for (int j = 0; j < MAX_POINTS - 1; j++) begin
                    r_stk[j] <= r_stk[j+1];
                end
            end
            bzev_pkg::S_WB: begin
                r_w <= w_full[31:0];
            end
            bzev_pkg::S_MUL: begin
                for (int a = 0; a < 3; a++) begin
                    r_prod[a] <= $signed({1'b0, r_w}) * r_v[a];
                end
            end
            bzev_pkg::S_ACC: begin
                for (int a = 0; a < 3; a++) begin
                    r_acc[a] <= r_acc[a] + ACW'(r_prod[a]);
                end
                r_i <= r_i + AW'(1);
            end
            bzev_pkg::S_RND: begin
                for (int a = 0; a < 3; a++) begin
                    r_rnd[a] <= acc_rnd[a][ACW-1:30];
                end
            end
            bzev_pkg::S_OUT: begin
                r_status <= 1'b0;
                for (int a = 0; a < 3; a++) begin
                    if (scaled[a] > SCW'(32'sh7FFF_FFFF)) begin
                        r_out[a] <= 32'sh7FFF_FFFF;
                    end else if (scaled[a] < -SCW'(33'sh8000_0000)) begin
                        r_out[a] <= 32'sh8000_0000;
                    end else begin
                        r_out[a] <= scaled[a][CW-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_out_x  = r_out[0];
    assign o_out_y  = r_out[1];
    assign o_out_z  = r_out[2];
    assign o_status = r_status;

endmodule
